// ----- rtl/polyphonic_voice_allocator_macros.svh -----
// Assertion macros for the voice allocator.
// Used by polyphonic_voice_allocator.sv; no other dependencies.
`ifndef POLYPHONIC_VOICE_ALLOCATOR_MACROS_SVH
`define POLYPHONIC_VOICE_ALLOCATOR_MACROS_SVH
// Assert that an antecedent implies a consequent in the same cycle.
`define PVA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Assert that an antecedent implies a consequent in the next cycle.
`define PVA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// ----- rtl/pva_pkg.sv -----
// Shared codes for the voice allocator.
// No dependencies.
package pva_pkg;
   typedef enum logic [1:0] {
      OP_NOTE_ON = 2'd0,
      OP_NOTE_OFF = 2'd1,
      OP_LEVEL = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE = 2'd0,
      ST_NOT_ACTIVE = 2'd1,
      ST_DUPLICATE = 2'd2,
      ST_NO_CHANGE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      STL_NONE = 2'd0,
      STL_RELEASING = 2'd1,
      STL_ACTIVE = 2'd2
   } stolen_type;

   typedef enum logic [1:0] {
      VS_FREE = 2'd0,
      VS_ACTIVE = 2'd1,
      VS_RELEASING = 2'd2
   } vstate_type;

   localparam int STAMP_BITS = 32;
endpackage

// ----- rtl/polyphonic_voice_allocator.sv -----
// Voice allocator: one command beat in, one result beat out, NUM_VOICES slots.
// Note-on and note-off go through scan, decide and strobe; a level report goes to decide
// and strobe; clear repeats scan and free per freed voice, then a last scan and the strobe.
// Sequential: busy is high until the rsp_valid strobe; the receiver cannot stall results.
// Synchronous active-high reset frees all voices; busy then stays high while the stack and records are swept.
// Depends on pva_pkg and polyphonic_voice_allocator_macros.svh.
`include "polyphonic_voice_allocator_macros.svh"
module polyphonic_voice_allocator
   import pva_pkg::*;
#(
   parameter int NUM_VOICES = 16,
   parameter int NOTE_ID_BITS = 16,
   parameter int LEVEL_BITS = 16
) (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input logic [1:0] req_operation,
   input logic [15:0] req_note_id,
   input logic [3:0] req_voice_index,
   input logic [15:0] req_level,
   input logic req_is_silent,
   input logic csr_write,
   input logic [4:0] csr_polyphony_limit,
   output logic rsp_valid,
   output logic [3:0] rsp_voice_out,
   output logic [1:0] rsp_status,
   output logic [1:0] rsp_stolen,
   output logic rsp_voice_freed
);
   localparam int VB = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
   localparam int CB = $clog2(NUM_VOICES + 1);
   localparam logic [CB-1:0] NV = CB'(NUM_VOICES);
   localparam logic [STAMP_BITS-1:0] SMAX = '1;
   localparam int NB = (NOTE_ID_BITS < 16) ? NOTE_ID_BITS : 16;
   localparam int LB = (LEVEL_BITS < 16) ? LEVEL_BITS : 16;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_DECIDE, S_CSCAN, S_CFREE, S_DONE
   } fsm_type;

   // Voice record memory: {note, age, release stamp, level}
   typedef struct packed {
      logic [NOTE_ID_BITS-1:0] note;
      logic [STAMP_BITS-1:0] age;
      logic [STAMP_BITS-1:0] rel;
      logic [LEVEL_BITS-1:0] level;
   } rec_type;

   rec_type rec_mem [NUM_VOICES];
   logic [VB-1:0] stack_mem [NUM_VOICES];
   rec_type rd_data_ff;
   logic [VB-1:0] stack_rd_ff;

   // Voice state flags stay in flip-flops (reset value given)
   vstate_type vst_ff [NUM_VOICES];

   fsm_type state_ff;
   logic [4:0] limit_ff;
   logic [CB-1:0] free_cnt_ff;
   logic [STAMP_BITS-1:0] age_cnt_ff, rel_cnt_ff;
   logic [1:0] op_ff;
   logic [NOTE_ID_BITS-1:0] note_ff;
   logic [VB-1:0] idx_ff;
   logic [LEVEL_BITS-1:0] lvl_ff;
   logic silent_ff;
   logic [CB-1:0] scan_ff;
   logic [CB-1:0] act_cnt_ff;
   logic dup_hit_ff, rel_hit_ff, act_hit_ff, min_hit_ff;
   logic [VB-1:0] dup_v_ff, rel_v_ff, act_v_ff, min_v_ff;
   logic [LEVEL_BITS-1:0] rel_lvl_ff;
   logic [LEVEL_BITS-1:0] dup_lvl_ff;
   logic [STAMP_BITS-1:0] rel_stamp_ff, act_age_ff, min_rel_ff;
   logic [NOTE_ID_BITS-1:0] act_note_ff;
   logic cl_phase_ff;
   logic init_ff;
   logic [CB-1:0] init_cnt_ff;

   logic rsp_valid_ff;
   logic [3:0] rsp_voice_ff;
   logic [1:0] rsp_status_ff, rsp_stolen_ff;
   logic rsp_freed_ff;

   logic [VB-1:0] scan_v;
   logic [VB-1:0] prev_v;
   logic accept;
   rec_type wr_data;
   logic wr_en;
   logic [VB-1:0] wr_addr;
   logic [VB-1:0] rd_addr;
   logic [VB-1:0] stk_rd_addr;
   logic stk_wr_en;
   logic [CB-1:0] stk_wr_addr;
   logic [VB-1:0] stk_wr_data;

   assign busy = (state_ff != S_IDLE) || init_ff;
   assign accept = start && !busy;
   assign scan_v = scan_ff[VB-1:0];
   assign prev_v = VB'(scan_ff - CB'(1));

   // Read ports: record at the request's voice index on accept, else at scan address; stack at top
   assign rd_addr = accept ? VB'(req_voice_index) : scan_v;
   assign stk_rd_addr = VB'(free_cnt_ff - CB'(1));
   always_ff @(posedge clock) begin
      rd_data_ff <= rec_mem[rd_addr];
      stack_rd_ff <= stack_mem[stk_rd_addr];
      if (wr_en) begin
         rec_mem[wr_addr] <= wr_data;
      end
      if (stk_wr_en) begin
         stack_mem[stk_wr_addr[VB-1:0]] <= stk_wr_data;
      end
   end

   // Decide-step signals
   logic steal;
   logic [VB-1:0] pick_v;
   logic pick_ok;
   logic [1:0] pick_stl;
   logic lvl_ok;
   always_comb begin
      steal = ({3'b000, act_cnt_ff} >= {{(CB+3-5){1'b0}}, limit_ff}) || (free_cnt_ff == '0);
      pick_v = '0;
      pick_ok = 1'b0;
      pick_stl = STL_NONE;
      if (steal && rel_hit_ff) begin
         pick_v = rel_v_ff; pick_ok = 1'b1; pick_stl = STL_RELEASING;
      end else if (steal && act_hit_ff) begin
         pick_v = act_v_ff; pick_ok = 1'b1; pick_stl = STL_ACTIVE;
      end else if (free_cnt_ff != '0) begin
         pick_v = stack_rd_ff; pick_ok = 1'b1;
      end
      lvl_ok = ({1'b0, idx_ff} < (VB+1)'(NUM_VOICES)) && (vst_ff[idx_ff] != VS_FREE);
   end

   // Voice freed in a clear pass: active voices first, lowest note id first; then releasing
   // voices oldest stamp first, and the quietest voice wins when it holds that oldest stamp
   logic [VB-1:0] cl_v;
   assign cl_v = cl_phase_ff ? ((rel_stamp_ff == min_rel_ff) ? rel_v_ff : min_v_ff)
                             : act_v_ff;

   // Memory write mux
   always_comb begin
      wr_en = 1'b0;
      wr_addr = '0;
      wr_data = rd_data_ff;
      stk_wr_en = 1'b0;
      stk_wr_addr = free_cnt_ff;
      stk_wr_data = '0;
      if (init_ff) begin
         stk_wr_en = 1'b1;
         stk_wr_addr = init_cnt_ff;
         stk_wr_data = VB'(init_cnt_ff);
         wr_en = 1'b1;
         wr_addr = VB'(init_cnt_ff);
         wr_data = '0;
      end else if (state_ff == S_DECIDE) begin
         case (op_ff)
            OP_NOTE_ON: begin
               if (!dup_hit_ff && pick_ok) begin
                  wr_en = 1'b1;
                  wr_addr = pick_v;
                  wr_data = rd_data_ff;
                  wr_data.note = note_ff;
                  wr_data.age = age_cnt_ff;
                  wr_data.level = '0;
               end
            end
            OP_NOTE_OFF: begin
               // Keep the level reported while the voice was active
               if (dup_hit_ff) begin
                  wr_en = 1'b1;
                  wr_addr = dup_v_ff;
                  wr_data = rd_data_ff;
                  wr_data.level = dup_lvl_ff;
                  wr_data.rel = rel_cnt_ff;
               end
            end
            OP_LEVEL: begin
               if (lvl_ok) begin
                  wr_en = 1'b1;
                  wr_addr = idx_ff;
                  wr_data = rd_data_ff;
                  if (vst_ff[idx_ff] == VS_RELEASING && silent_ff) begin
                     wr_data.level = '0;
                     stk_wr_en = (free_cnt_ff < NV);
                     stk_wr_data = idx_ff;
                  end else begin
                     wr_data.level = lvl_ff;
                  end
               end
            end
            default: begin
            end
         endcase
      end else if (state_ff == S_CFREE) begin
         wr_en = 1'b1;
         wr_addr = cl_v;
         wr_data = rd_data_ff;
         wr_data.level = '0;
         stk_wr_en = (free_cnt_ff < NV);
         stk_wr_data = cl_v;
      end
   end

   // Control, scan and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         limit_ff <= 5'd16;
         free_cnt_ff <= NV;
         age_cnt_ff <= '0;
         rel_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
         init_ff <= 1'b1;
         init_cnt_ff <= '0;
         for (int i = 0; i < NUM_VOICES; i++) begin
            vst_ff[i] <= VS_FREE;
         end
      end else begin
         rsp_valid_ff <= 1'b0;
         if (csr_write) begin
            limit_ff <= csr_polyphony_limit;
         end
         // Sweep the stack and records once after reset
         if (init_ff) begin
            init_cnt_ff <= init_cnt_ff + CB'(1);
            if (init_cnt_ff == NV - CB'(1)) begin
               init_ff <= 1'b0;
            end
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  op_ff <= req_operation;
                  note_ff <= NOTE_ID_BITS'(req_note_id[NB-1:0]);
                  idx_ff <= VB'(req_voice_index);
                  lvl_ff <= LEVEL_BITS'(req_level[LB-1:0]);
                  silent_ff <= req_is_silent;
                  scan_ff <= '0;
                  act_cnt_ff <= '0;
                  dup_hit_ff <= 1'b0;
                  rel_hit_ff <= 1'b0;
                  act_hit_ff <= 1'b0;
                  min_hit_ff <= 1'b0;
                  cl_phase_ff <= 1'b0;
                  rsp_voice_ff <= '0;
                  rsp_stolen_ff <= STL_NONE;
                  rsp_freed_ff <= 1'b0;
                  if (req_operation == OP_LEVEL) begin
                     state_ff <= S_DECIDE;
                  end else if (req_operation == OP_CLEAR) begin
                     state_ff <= S_CSCAN;
                  end else begin
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_SCAN, S_CSCAN: begin
               // Record of voice scan-1 is on the read port
               if (scan_ff != '0) begin
                  if (vst_ff[prev_v] == VS_ACTIVE) begin
                     act_cnt_ff <= act_cnt_ff + CB'(1);
                     if (!dup_hit_ff && rd_data_ff.note == note_ff) begin
                        dup_hit_ff <= 1'b1;
                        dup_v_ff <= prev_v;
                        dup_lvl_ff <= rd_data_ff.level;
                     end
                     if (!act_hit_ff || (state_ff == S_SCAN ?
                         rd_data_ff.age < act_age_ff : rd_data_ff.note < act_note_ff)) begin
                        act_hit_ff <= 1'b1;
                        act_v_ff <= prev_v;
                        act_age_ff <= rd_data_ff.age;
                        act_note_ff <= rd_data_ff.note;
                     end
                  end
                  if (vst_ff[prev_v] == VS_RELEASING) begin
                     // Track the quietest voice and the oldest release stamp
                     if (!rel_hit_ff || rd_data_ff.level < rel_lvl_ff ||
                         (rd_data_ff.level == rel_lvl_ff && rd_data_ff.rel < rel_stamp_ff)) begin
                        rel_hit_ff <= 1'b1;
                        rel_v_ff <= prev_v;
                        rel_lvl_ff <= rd_data_ff.level;
                        rel_stamp_ff <= rd_data_ff.rel;
                     end
                     if (!min_hit_ff || rd_data_ff.rel < min_rel_ff) begin
                        min_hit_ff <= 1'b1;
                        min_v_ff <= prev_v;
                        min_rel_ff <= rd_data_ff.rel;
                     end
                  end
               end
               if (scan_ff == NV) begin
                  if (state_ff == S_SCAN) begin
                     scan_ff <= {1'b0, (CB-1)'(0)};
                     state_ff <= S_DECIDE;
                  end else if (act_hit_ff || (vst_ff[prev_v] == VS_ACTIVE)) begin
                     cl_phase_ff <= 1'b0;
                     state_ff <= S_CFREE;
                  end else if (rel_hit_ff || (vst_ff[prev_v] == VS_RELEASING)) begin
                     cl_phase_ff <= 1'b1;
                     state_ff <= S_CFREE;
                  end else begin
                     age_cnt_ff <= '0;
                     rel_cnt_ff <= '0;
                     rsp_status_ff <= ST_DONE;
                     state_ff <= S_DONE;
                  end
               end else begin
                  scan_ff <= scan_ff + CB'(1);
               end
            end
            S_CFREE: begin
               // Push one voice, then rescan
               vst_ff[cl_v] <= VS_FREE;
               if (free_cnt_ff < NV) begin
                  free_cnt_ff <= free_cnt_ff + CB'(1);
               end
               scan_ff <= '0;
               act_hit_ff <= 1'b0;
               rel_hit_ff <= 1'b0;
               min_hit_ff <= 1'b0;
               state_ff <= S_CSCAN;
            end
            S_DECIDE: begin
               state_ff <= S_DONE;
               rsp_status_ff <= ST_NO_CHANGE;
               case (op_ff)
                  OP_NOTE_ON: begin
                     if (dup_hit_ff) begin
                        rsp_voice_ff <= 4'(dup_v_ff);
                        rsp_status_ff <= ST_DUPLICATE;
                     end else if (pick_ok) begin
                        vst_ff[pick_v] <= VS_ACTIVE;
                        if (pick_stl == STL_NONE) begin
                           free_cnt_ff <= free_cnt_ff - CB'(1);
                        end
                        if (age_cnt_ff != SMAX) begin
                           age_cnt_ff <= age_cnt_ff + STAMP_BITS'(1);
                        end
                        rsp_voice_ff <= 4'(pick_v);
                        rsp_stolen_ff <= pick_stl;
                        rsp_status_ff <= ST_DONE;
                     end
                  end
                  OP_NOTE_OFF: begin
                     if (dup_hit_ff) begin
                        vst_ff[dup_v_ff] <= VS_RELEASING;
                        if (rel_cnt_ff != SMAX) begin
                           rel_cnt_ff <= rel_cnt_ff + STAMP_BITS'(1);
                        end
                        rsp_voice_ff <= 4'(dup_v_ff);
                        rsp_status_ff <= ST_DONE;
                     end else begin
                        rsp_status_ff <= ST_NOT_ACTIVE;
                     end
                  end
                  OP_LEVEL: begin
                     rsp_voice_ff <= 4'(idx_ff);
                     if (lvl_ok) begin
                        rsp_status_ff <= ST_DONE;
                        if (vst_ff[idx_ff] == VS_RELEASING && silent_ff) begin
                           vst_ff[idx_ff] <= VS_FREE;
                           rsp_freed_ff <= 1'b1;
                           if (free_cnt_ff < NV) begin
                              free_cnt_ff <= free_cnt_ff + CB'(1);
                           end
                           if (free_cnt_ff >= NV - CB'(1)) begin
                              age_cnt_ff <= '0;
                              rel_cnt_ff <= '0;
                           end
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
            S_DONE: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_voice_out = rsp_voice_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_stolen = rsp_stolen_ff;
   assign rsp_voice_freed = rsp_freed_ff;

   `PVA_ASSERT_IMP(a_no_accept_busy, clock, reset, rsp_valid_ff, state_ff == S_IDLE, "result outside idle")
   `PVA_ASSERT_IMP(a_free_cnt_range, clock, reset, 1'b1, free_cnt_ff <= NV, "free count overflow")
   `PVA_ASSERT_NEXT(a_done_strobe, clock, reset, state_ff == S_DONE, rsp_valid_ff, "missing result strobe")
   `PVA_ASSERT_IMP(a_stolen_status, clock, reset, rsp_valid_ff && rsp_stolen_ff != STL_NONE, rsp_status_ff == ST_DONE, "steal without done")
endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for polyphonic_voice_allocator: note-on, note-off,
// level reports and clear are predicted in-bench and compared beat by beat.
// Depends on pva_pkg and the allocator RTL.
module tb;
   import pva_pkg::*;

   localparam int NV = 16;
   localparam longint CYCLE_LIMIT = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_operation = '0;
   logic [15:0] req_note_id = '0;
   logic [3:0] req_voice_index = '0;
   logic [15:0] req_level = '0;
   logic req_is_silent = 1'b0;
   logic csr_write = 1'b0;
   logic [4:0] csr_polyphony_limit = 5'd16;
   logic rsp_valid;
   logic [3:0] rsp_voice_out;
   logic [1:0] rsp_status;
   logic [1:0] rsp_stolen;
   logic rsp_voice_freed;

   typedef struct packed {
      logic [3:0] voice;
      status_type status;
      stolen_type stolen;
      logic freed;
   } alloc_result_type;

   alloc_result_type expected_results[$];
   int error_count = 0;
   longint cycle_count = 0;
   int send_idle_pct = 0;
   logic [15:0] note_pool[$];

   // allocator shadow state
   vstate_type shadow_state[NV];
   logic [15:0] shadow_note[NV];
   logic [31:0] shadow_age[NV];
   logic [31:0] shadow_rel[NV];
   logic [15:0] shadow_level[NV];
   logic [3:0] shadow_stack[NV];
   int shadow_free_count;
   logic [31:0] shadow_age_ctr;
   logic [31:0] shadow_rel_ctr;
   logic [4:0] shadow_limit;

   polyphonic_voice_allocator u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_note_id(req_note_id),
      .req_voice_index(req_voice_index), .req_level(req_level),
      .req_is_silent(req_is_silent), .csr_write(csr_write),
      .csr_polyphony_limit(csr_polyphony_limit), .rsp_valid(rsp_valid),
      .rsp_voice_out(rsp_voice_out), .rsp_status(rsp_status),
      .rsp_stolen(rsp_stolen), .rsp_voice_freed(rsp_voice_freed)
   );

   always #5 clock = ~clock;

   // bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      error_count++;
      $display("mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   function automatic void reset_shadow();
      for (int v = 0; v < NV; v++) begin
         shadow_state[v] = VS_FREE;
         shadow_note[v] = '0;
         shadow_age[v] = '0;
         shadow_rel[v] = '0;
         shadow_level[v] = '0;
         shadow_stack[v] = v[3:0];
      end
      shadow_free_count = NV;
      shadow_age_ctr = '0;
      shadow_rel_ctr = '0;
      shadow_limit = 5'd16;
   endfunction

   function automatic void release_to_stack(int v);
      if (shadow_free_count < NV) begin
         shadow_stack[shadow_free_count] = v[3:0];
         shadow_free_count++;
      end
      shadow_state[v] = VS_FREE;
      shadow_level[v] = '0;
      if (shadow_free_count == NV) begin
         shadow_age_ctr = '0;
         shadow_rel_ctr = '0;
      end
   endfunction

   function automatic int holder_of(logic [15:0] note);
      for (int v = 0; v < NV; v++)
         if (shadow_state[v] == VS_ACTIVE && shadow_note[v] == note) return v;
      return -1;
   endfunction

   function automatic int quietest_releasing();
      int best;
      best = -1;
      for (int v = 0; v < NV; v++) begin
         if (shadow_state[v] != VS_RELEASING) continue;
         if (best < 0 || shadow_level[v] < shadow_level[best] ||
             (shadow_level[v] == shadow_level[best] && shadow_rel[v] < shadow_rel[best]))
            best = v;
      end
      return best;
   endfunction

   // compute the result of one command and advance the shadow state
   function automatic alloc_result_type allocate_step(op_type op, logic [15:0] note,
         logic [3:0] idx, logic [15:0] lvl, logic silent);
      alloc_result_type r;
      int v, best, active;
      r = '{voice: 4'd0, status: ST_NO_CHANGE, stolen: STL_NONE, freed: 1'b0};
      case (op)
         OP_NOTE_ON: begin
            v = holder_of(note);
            if (v >= 0) begin
               r.voice = v[3:0];
               r.status = ST_DUPLICATE;
            end else begin
               active = 0;
               for (int i = 0; i < NV; i++) if (shadow_state[i] == VS_ACTIVE) active++;
               v = -1;
               if (active >= shadow_limit || shadow_free_count == 0) begin
                  v = quietest_releasing();
                  if (v >= 0) r.stolen = STL_RELEASING;
                  else begin
                     for (int i = 0; i < NV; i++)
                        if (shadow_state[i] == VS_ACTIVE &&
                            (v < 0 || shadow_age[i] < shadow_age[v])) v = i;
                     if (v >= 0) r.stolen = STL_ACTIVE;
                  end
               end
               if (v < 0 && shadow_free_count > 0) begin
                  shadow_free_count--;
                  v = shadow_stack[shadow_free_count];
               end
               if (v >= 0) begin
                  shadow_state[v] = VS_ACTIVE;
                  shadow_note[v] = note;
                  shadow_age[v] = shadow_age_ctr;
                  shadow_level[v] = '0;
                  if (shadow_age_ctr != '1) shadow_age_ctr++;
                  r.voice = v[3:0];
                  r.status = ST_DONE;
               end
            end
         end
         OP_NOTE_OFF: begin
            v = holder_of(note);
            if (v < 0) r.status = ST_NOT_ACTIVE;
            else begin
               shadow_state[v] = VS_RELEASING;
               shadow_rel[v] = shadow_rel_ctr;
               if (shadow_rel_ctr != '1) shadow_rel_ctr++;
               r.voice = v[3:0];
               r.status = ST_DONE;
            end
         end
         OP_LEVEL: begin
            r.voice = idx;
            if (shadow_state[idx] != VS_FREE) begin
               r.status = ST_DONE;
               if (shadow_state[idx] == VS_RELEASING && silent) begin
                  release_to_stack(idx);
                  r.freed = 1'b1;
               end else shadow_level[idx] = lvl;
            end
         end
         default: begin
            // free active voices by ascending note id, then releasing by stamp,
            // starting from the quietest voice
            forever begin
               best = -1;
               for (int i = 0; i < NV; i++)
                  if (shadow_state[i] == VS_ACTIVE &&
                      (best < 0 || shadow_note[i] < shadow_note[best])) best = i;
               if (best < 0) break;
               release_to_stack(best);
            end
            forever begin
               best = quietest_releasing();
               if (best < 0) break;
               for (int i = 0; i < NV; i++)
                  if (shadow_state[i] == VS_RELEASING &&
                      shadow_rel[i] < shadow_rel[best]) best = i;
               release_to_stack(best);
            end
            shadow_age_ctr = '0;
            shadow_rel_ctr = '0;
            r.status = ST_DONE;
         end
      endcase
      return r;
   endfunction

   // check each result beat against the oldest prediction
   always @(posedge clock) begin
      alloc_result_type want;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) report_mismatch("result with none expected");
         else begin
            want = expected_results.pop_front();
            if (rsp_voice_out !== want.voice)
               report_mismatch($sformatf("voice_out %0d want %0d", rsp_voice_out, want.voice));
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %0d want %0d", rsp_status, want.status));
            if (rsp_stolen !== want.stolen)
               report_mismatch($sformatf("stolen %0d want %0d", rsp_stolen, want.stolen));
            if (rsp_voice_freed !== want.freed)
               report_mismatch($sformatf("freed %0d want %0d", rsp_voice_freed, want.freed));
         end
      end
   end

   // send one command beat; wait for acceptance, then drop start
   task automatic send_command(op_type op, logic [15:0] note, logic [3:0] idx,
         logic [15:0] lvl, logic silent);
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      start <= 1'b1;
      req_operation <= op;
      req_note_id <= note;
      req_voice_index <= idx;
      req_level <= lvl;
      req_is_silent <= silent;
      do @(posedge clock); while (busy);
      expected_results.insert(expected_results.size(),
                              allocate_step(op, note, idx, lvl, silent));
      start <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_results();
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(logic [4:0] lim);
      drain_results();
      csr_write <= 1'b1;
      csr_polyphony_limit <= lim;
      @(posedge clock);
      csr_write <= 1'b0;
      shadow_limit = lim;
   endtask

   task automatic test_directed();
      send_command(OP_LEVEL, 16'h0, 4'd15, 16'hFFFF, 1'b1);
      send_command(OP_NOTE_OFF, 16'hFFFF, 4'd0, 16'h0, 1'b0);
      send_command(OP_NOTE_ON, 16'h0000, 4'd0, 16'h0, 1'b0);
      send_command(OP_NOTE_ON, 16'hFFFF, 4'd0, 16'h0, 1'b0);
      send_command(OP_NOTE_ON, 16'hFFFF, 4'd0, 16'h0, 1'b0);
      send_command(OP_NOTE_ON, 16'h1234, 4'd0, 16'h0, 1'b0);
      send_command(OP_LEVEL, 16'h0, 4'd15, 16'hFFFF, 1'b1);
      send_command(OP_NOTE_OFF, 16'hFFFF, 4'd0, 16'h0, 1'b0);
      send_command(OP_NOTE_OFF, 16'h1234, 4'd0, 16'h0, 1'b0);
      send_command(OP_LEVEL, 16'h0, 4'd14, 16'h0010, 1'b0);
      send_command(OP_LEVEL, 16'h0, 4'd13, 16'h0010, 1'b0);
      // force a steal from releasing with level tie
      write_limit(5'd1);
      send_command(OP_NOTE_ON, 16'h5555, 4'd0, 16'h0, 1'b0);
      send_command(OP_NOTE_ON, 16'hAAAA, 4'd0, 16'h0, 1'b0);
      send_command(OP_NOTE_ON, 16'h0F0F, 4'd0, 16'h0, 1'b0);
      send_command(OP_LEVEL, 16'h0, 4'd13, 16'h0, 1'b1);
      send_command(OP_CLEAR, 16'h0, 4'd0, 16'h0, 1'b0);
      // nothing to steal: limit 0 pops a free voice
      write_limit(5'd0);
      send_command(OP_NOTE_ON, 16'h0042, 4'd0, 16'h0, 1'b0);
      send_command(OP_NOTE_ON, 16'h0043, 4'd0, 16'h0, 1'b0);
      send_command(OP_NOTE_OFF, 16'h0043, 4'd0, 16'h0, 1'b0);
      send_command(OP_LEVEL, 16'h0, 4'd15, 16'h0, 1'b1);
      send_command(OP_CLEAR, 16'h0, 4'd0, 16'h0, 1'b0);
      write_limit(5'd16);
   endtask

   // random traffic over a small note pool to reach steals and duplicates
   task automatic test_random(int count);
      logic [15:0] note;
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         note = (note_pool.size() > 0 && $urandom_range(3) != 0) ?
                note_pool[$urandom_range(note_pool.size() - 1)] : 16'($urandom);
         if (note_pool.size() < 24) note_pool.insert(note_pool.size(), note);
         if (pick < 40) send_command(OP_NOTE_ON, note, 4'($urandom), 16'($urandom), 1'($urandom));
         else if (pick < 65)
            send_command(OP_NOTE_OFF, note, 4'($urandom), 16'($urandom), 1'($urandom));
         else if (pick < 97)
            send_command(OP_LEVEL, 16'($urandom), 4'($urandom),
                         ($urandom_range(3) == 0) ? 16'($urandom_range(3)) : 16'($urandom),
                         1'($urandom_range(2) == 0));
         else send_command(OP_CLEAR, 16'($urandom), 4'($urandom), 16'($urandom), 1'($urandom));
      end
   endtask

   initial begin
      reset_shadow();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(100);
      write_limit(5'd4);
      send_idle_pct = 85;
      test_random(100);
      // hold off until every result has come
      drain_results();
      write_limit(5'd1);
      send_idle_pct = 22;
      test_random(100);
      write_limit(5'd16);
      send_idle_pct = 0;
      test_random(150);
      write_limit(5'($urandom_range(2, 15)));
      send_idle_pct = 85;
      test_random(150);
      drain_results();
      repeat (300) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule

// ----- polyphonic_voice_allocator.f -----
+incdir+rtl
rtl/pva_pkg.sv
rtl/polyphonic_voice_allocator.sv
tb/tb.sv
